### design/pidci_pkg.sv
// shared types, constants and fixed-point helpers for the pid conditional integration block
// no dependencies; every other design file imports this package
package pidci_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned StepW   = 31;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned DivBits = 49;
  localparam int unsigned DivCntW = 6;
  localparam int unsigned WideW   = 49;
  localparam int unsigned SumW    = 34;
  localparam int unsigned MulW    = 33;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned FracW   = 16;

  localparam logic [RegIdxW-1:0] RegPropGain     = 3'd0;
  localparam logic [RegIdxW-1:0] RegIntegGain    = 3'd1;
  localparam logic [RegIdxW-1:0] RegDerivGain    = 3'd2;
  localparam logic [RegIdxW-1:0] RegDriveFloor   = 3'd3;
  localparam logic [RegIdxW-1:0] RegDriveCeiling = 3'd4;
  localparam logic [RegIdxW-1:0] RegAccumFloor   = 3'd5;
  localparam logic [RegIdxW-1:0] RegAccumCeiling = 3'd6;

  localparam logic signed [DataW-1:0] LimitLowRst  = -32'sd65536;
  localparam logic signed [DataW-1:0] LimitHighRst = 32'sd65536;
  localparam logic signed [DataW-1:0] Max32        = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] Min32        = 32'sh80000000;
  localparam logic signed [WideW-1:0] Max32Wide    = 49'sd2147483647;
  localparam logic signed [WideW-1:0] Min32Wide    = -49'sd2147483648;

  typedef struct packed {
    logic signed [DataW-1:0] prop_gain;
    logic signed [DataW-1:0] integ_gain;
    logic signed [DataW-1:0] deriv_gain;
    logic signed [DataW-1:0] drive_floor;
    logic signed [DataW-1:0] drive_ceiling;
    logic signed [DataW-1:0] accum_floor;
    logic signed [DataW-1:0] accum_ceiling;
  } pidci_cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESTART,
    OP_ZERO,
    OP_ERR,
    OP_MUL_P,
    OP_TAKE_P,
    OP_MUL_INC,
    OP_TAKE_INC,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_MUL_D,
    OP_TAKE_D,
    OP_TENT,
    OP_MUL_KT,
    OP_TAKE_KT,
    OP_HOLD,
    OP_MUL_KA,
    OP_TAKE_KA,
    OP_SUM,
    OP_EMIT
  } pidci_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_P,
    ST_TAKE_P,
    ST_MUL_INC,
    ST_TAKE_INC,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_DIV_END,
    ST_MUL_D,
    ST_TAKE_D,
    ST_TENT,
    ST_MUL_KT,
    ST_TAKE_KT,
    ST_HOLD,
    ST_MUL_KA,
    ST_TAKE_KA,
    ST_SUM,
    ST_EMIT
  } pidci_state_t;

  typedef struct packed {
    logic mode;
    logic dt_zero;
    logic have_last;
    logic held;
    logic div_last;
    logic out_free;
  } pidci_status_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
    if (v > Max32Wide) return Max32;
    if (v < Min32Wide) return Min32;
    return v[DataW-1:0];
  endfunction

  // floor tests first so inverted limits give the floor
  function automatic logic signed [DataW-1:0] clamp32(input logic signed [WideW-1:0] x,
                                                      input logic signed [DataW-1:0] lo,
                                                      input logic signed [DataW-1:0] hi);
    if (x < WideW'(lo)) return lo;
    if (x > WideW'(hi)) return hi;
    return x[DataW-1:0];
  endfunction

  // q16.16 product back to q16.16: floor shift then saturate
  function automatic logic signed [DataW-1:0] qscale(input logic signed [ProdW-1:0] p);
    return sat32(WideW'($signed(p[ProdW-1:FracW])));
  endfunction

endpackage

### design/pidci_if.sv
// valid/ready channel interfaces for the pid conditional integration block
// depends on pidci_pkg for field widths
interface pidci_in_if;
  import pidci_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [DataW-1:0] target;
  logic signed [DataW-1:0] sensed;
  logic [StepW-1:0]        step_time;

  modport source (output valid, mode, target, sensed, step_time, input ready);
  modport sink (input valid, mode, target, sensed, step_time, output ready);
endinterface

interface pidci_out_if;
  import pidci_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] drive;
  logic                    integ_held;

  modport source (output valid, drive, integ_held, input ready);
  modport sink (input valid, drive, integ_held, output ready);
endinterface

### design/pid_conditional_integration_top.sv
// pid controller, derivative on measurement, conditional integration: top level
// Channels: in_ch (sink) carries mode, target, sensed and step_time; out_ch
// (source) carries drive and integ_held. A transaction moves on a rising edge
// with valid and ready both high. Gains and limits are written through
// cfg_we / cfg_index / cfg_data; the user must write them only while the
// block is idle, which the block does not enforce. Indexes past the last
// register are ignored. One transaction is worked at a time. A restart or a
// zero time step goes straight to the result. An update forms the error, the
// P term and the integrator increment; with a previous measurement the 49-bit
// restoring divider forms the measurement rate for the D term. The single
// shared 33x33 multiplier is used up to five times, each in a multiply and a
// take state. in_ch.ready rises the cycle after the result is written, so a
// new item is taken only once the last is through. The result sits in an
// output register: while the receiver stalls the block already accepts and
// works the next transaction and waits only to write its result. Reset
// clears the integrator, the measurement history, the output valid flag and
// loads the default gains and limits.
module pid_conditional_integration_top (
  input  logic                           clk,
  input  logic                           rst,
  pidci_in_if.sink                       in_ch,
  pidci_out_if.source                    out_ch,
  input  logic                           cfg_we,
  input  logic [pidci_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [pidci_pkg::DataW-1:0]    cfg_data
);
  import pidci_pkg::*;

  pidci_cfg_t    cfg;
  pidci_op_t     op;
  pidci_status_t sts;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  pidci_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  pidci_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .op       (op)
  );

  pidci_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .sts          (sts),
    .cfg          (cfg),
    .in_mode      (in_ch.mode),
    .in_target    (in_ch.target),
    .in_sensed    (in_ch.sensed),
    .in_step_time (in_ch.step_time),
    .out          (out_ch)
  );

endmodule

### design/pidci_regs.sv
// configuration register bank: gains and limits, written by index
// depends on pidci_pkg
module pidci_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [pidci_pkg::RegIdxW-1:0]    index,
  input  logic [pidci_pkg::DataW-1:0]      data,
  output pidci_pkg::pidci_cfg_t            cfg
);
  import pidci_pkg::*;

  pidci_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.prop_gain     <= '0;
      cfg_r.integ_gain    <= '0;
      cfg_r.deriv_gain    <= '0;
      cfg_r.drive_floor   <= LimitLowRst;
      cfg_r.drive_ceiling <= LimitHighRst;
      cfg_r.accum_floor   <= LimitLowRst;
      cfg_r.accum_ceiling <= LimitHighRst;
    end else if (we) begin
      case (index)
        RegPropGain:     cfg_r.prop_gain     <= data;
        RegIntegGain:    cfg_r.integ_gain    <= data;
        RegDerivGain:    cfg_r.deriv_gain    <= data;
        RegDriveFloor:   cfg_r.drive_floor   <= data;
        RegDriveCeiling: cfg_r.drive_ceiling <= data;
        RegAccumFloor:   cfg_r.accum_floor   <= data;
        RegAccumCeiling: cfg_r.accum_ceiling <= data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### design/pidci_dp.sv
// datapath: shared multiplier, serial divider, loop state and output register
// depends on pidci_pkg and pidci_if
module pidci_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  pidci_pkg::pidci_op_t           op,
  output pidci_pkg::pidci_status_t       sts,
  input  pidci_pkg::pidci_cfg_t          cfg,
  input  logic                           in_mode,
  input  logic signed [pidci_pkg::DataW-1:0] in_target,
  input  logic signed [pidci_pkg::DataW-1:0] in_sensed,
  input  logic [pidci_pkg::StepW-1:0]    in_step_time,
  pidci_out_if.source                    out
);
  import pidci_pkg::*;

  // captured transaction
  logic                    mode_r;
  logic signed [DataW-1:0] tgt_r;
  logic signed [DataW-1:0] sen_r;
  logic [StepW-1:0]        dt_r;

  // loop state
  logic signed [DataW-1:0] accum;
  logic signed [DataW-1:0] last_sensed;
  logic                    have_last;

  // working registers
  logic signed [DataW-1:0]       err;
  logic signed [DataW-1:0]       p_term;
  logic signed [DataW-1:0]       d_term;
  logic signed [DataW-1:0]       rate;
  logic signed [DataW-1:0]       tent;
  logic signed [DataW-1:0]       kt;
  logic signed [DataW-1:0]       i_term;
  logic signed [ProdW-FracW-1:0] inc;
  logic signed [ProdW-1:0]       prod;
  logic signed [DataW-1:0]       drive_r;
  logic                          held_r;

  // restoring divider
  logic [StepW-1:0]   div_rem;
  logic [DivBits-1:0] div_quo;
  logic               div_neg;
  logic [DivCntW-1:0] div_cnt;

  logic                    out_valid_r;
  logic signed [DataW-1:0] out_drive_r;
  logic                    out_held_r;

  logic signed [DataW:0]         diff;
  logic [DataW:0]                diff_mag;
  logic signed [DataW:0]         err_wide;
  logic [DataW-1:0]              rem_sh;
  logic [DataW:0]                trial;
  logic                          quo_bit;
  logic [StepW-1:0]              rem_next;
  logic                          quo_big;
  logic signed [DataW-1:0]       rate_next;
  logic signed [MulW-1:0]        mul_a;
  logic signed [MulW-1:0]        mul_b;
  logic signed [2*MulW-1:0]      mul_full;
  logic signed [WideW-1:0]       d_shift;
  logic signed [SumW-1:0]        tent_out;
  logic signed [SumW-1:0]        sum_out;
  logic                          err_pos;
  logic                          err_neg;
  logic                          held_c;
  logic                          out_free;

  assign diff     = (DataW+1)'(sen_r) - (DataW+1)'(last_sensed);
  assign diff_mag = diff[DataW] ? (DataW+1)'(-diff) : (DataW+1)'(diff);
  assign err_wide = (DataW+1)'(tgt_r) - (DataW+1)'(sen_r);

  // one quotient bit per cycle
  assign rem_sh   = {div_rem, div_quo[DivBits-1]};
  assign trial    = {1'b0, rem_sh} - {2'b00, dt_r};
  assign quo_bit  = !trial[DataW];
  assign rem_next = quo_bit ? trial[StepW-1:0] : rem_sh[StepW-1:0];

  // quotient magnitude to signed, saturating
  assign quo_big = |div_quo[DivBits-1:DataW-1];
  always_comb begin
    if (div_neg) begin
      rate_next = quo_big ? Min32 : $signed(~div_quo[DataW-1:0] + 32'd1);
    end else begin
      rate_next = quo_big ? Max32 : $signed(div_quo[DataW-1:0]);
    end
  end

  always_comb begin
    case (op)
      OP_MUL_P: begin
        mul_a = MulW'(cfg.prop_gain);
        mul_b = MulW'(err);
      end
      OP_MUL_INC: begin
        mul_a = MulW'(err);
        mul_b = $signed({2'b00, dt_r});
      end
      OP_MUL_D: begin
        mul_a = MulW'(cfg.deriv_gain);
        mul_b = MulW'(rate);
      end
      OP_MUL_KT: begin
        mul_a = MulW'(cfg.integ_gain);
        mul_b = MulW'(tent);
      end
      OP_MUL_KA: begin
        mul_a = MulW'(cfg.integ_gain);
        mul_b = MulW'(accum);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign d_shift  = WideW'($signed(prod[ProdW-1:FracW]));

  assign tent_out = SumW'(p_term) + SumW'(kt) + SumW'(d_term);
  assign sum_out  = SumW'(p_term) + SumW'(i_term) + SumW'(d_term);
  assign err_pos  = !err[DataW-1] && (err != '0);
  assign err_neg  = err[DataW-1];
  // hold the integrator when the output would saturate in the direction of the error
  assign held_c   = ((tent_out >= SumW'(cfg.drive_ceiling)) && err_pos) ||
                    ((tent_out <= SumW'(cfg.drive_floor)) && err_neg);

  assign out_free = !out_valid_r || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accum       <= '0;
      last_sensed <= '0;
      have_last   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (op)
        OP_RESTART: begin
          accum       <= '0;
          last_sensed <= '0;
          have_last   <= 1'b0;
        end
        OP_TENT: begin
          last_sensed <= sen_r;
          have_last   <= 1'b1;
        end
        OP_HOLD: begin
          if (!held_c) accum <= tent;
        end
        default: ;
      endcase
      if (op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        mode_r <= in_mode;
        tgt_r  <= in_target;
        sen_r  <= in_sensed;
        dt_r   <= in_step_time;
      end
      OP_RESTART, OP_ZERO: begin
        drive_r <= '0;
        held_r  <= 1'b0;
      end
      OP_ERR: err <= sat32(WideW'(err_wide));
      OP_MUL_P, OP_MUL_INC, OP_MUL_D, OP_MUL_KT, OP_MUL_KA: prod <= mul_full[ProdW-1:0];
      OP_TAKE_P: p_term <= qscale(prod);
      OP_TAKE_INC: begin
        inc    <= $signed(prod[ProdW-1:FracW]);
        d_term <= '0;
      end
      OP_DIV_START: begin
        div_quo <= {diff_mag, FracW'(0)};
        div_rem <= '0;
        div_neg <= diff[DataW];
        div_cnt <= DivCntW'(DivBits - 1);
      end
      OP_DIV_STEP: begin
        div_rem <= rem_next;
        div_quo <= {div_quo[DivBits-2:0], quo_bit};
        div_cnt <= div_cnt - DivCntW'(1);
      end
      OP_DIV_END: rate <= rate_next;
      OP_TAKE_D: d_term <= sat32(-d_shift);
      OP_TENT: tent <= clamp32(WideW'(accum) + WideW'(inc), cfg.accum_floor, cfg.accum_ceiling);
      OP_TAKE_KT: kt <= qscale(prod);
      OP_HOLD: begin
        held_r <= held_c;
        i_term <= kt;
      end
      OP_TAKE_KA: i_term <= qscale(prod);
      OP_SUM: drive_r <= clamp32(WideW'(sum_out), cfg.drive_floor, cfg.drive_ceiling);
      OP_EMIT: begin
        out_drive_r <= drive_r;
        out_held_r  <= held_r;
      end
      default: ;
    endcase
  end

  assign sts.mode      = mode_r;
  assign sts.dt_zero   = (dt_r == '0);
  assign sts.have_last = have_last;
  assign sts.held      = held_c;
  assign sts.div_last  = (div_cnt == '0);
  assign sts.out_free  = out_free;

  assign out.valid      = out_valid_r;
  assign out.drive      = out_drive_r;
  assign out.integ_held = out_held_r;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT) |-> (!out_valid_r || out.ready))
    else $error("result written over a pending transaction");
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (op == OP_RESTART) |=> (!have_last && accum == '0 && last_sensed == '0))
    else $error("restart did not clear loop state");
  a_zero_keeps: assert property (@(posedge clk) disable iff (rst)
    (op == OP_ZERO) |=> (accum == $past(accum) && have_last == $past(have_last)))
    else $error("zero time step changed loop state");
  a_held_keeps: assert property (@(posedge clk) disable iff (rst)
    (op == OP_HOLD && held_c) |=> (accum == $past(accum)))
    else $error("integrator moved while held");
`endif

endmodule

### design/pidci_ctrl.sv
// controller: sequences one transaction through the datapath
// depends on pidci_pkg
module pidci_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pidci_pkg::pidci_status_t sts,
  output pidci_pkg::pidci_op_t     op
);
  import pidci_pkg::*;

  pidci_state_t state;
  pidci_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.mode) begin
          op         = OP_RESTART;
          state_next = ST_EMIT;
        end else if (sts.dt_zero) begin
          op         = OP_ZERO;
          state_next = ST_EMIT;
        end else begin
          op         = OP_ERR;
          state_next = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        op         = OP_MUL_P;
        state_next = ST_TAKE_P;
      end
      ST_TAKE_P: begin
        op         = OP_TAKE_P;
        state_next = ST_MUL_INC;
      end
      ST_MUL_INC: begin
        op         = OP_MUL_INC;
        state_next = ST_TAKE_INC;
      end
      ST_TAKE_INC: begin
        op         = OP_TAKE_INC;
        state_next = sts.have_last ? ST_DIV_START : ST_TENT;
      end
      ST_DIV_START: begin
        op         = OP_DIV_START;
        state_next = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        op = OP_DIV_STEP;
        if (sts.div_last) state_next = ST_DIV_END;
      end
      ST_DIV_END: begin
        op         = OP_DIV_END;
        state_next = ST_MUL_D;
      end
      ST_MUL_D: begin
        op         = OP_MUL_D;
        state_next = ST_TAKE_D;
      end
      ST_TAKE_D: begin
        op         = OP_TAKE_D;
        state_next = ST_TENT;
      end
      ST_TENT: begin
        op         = OP_TENT;
        state_next = ST_MUL_KT;
      end
      ST_MUL_KT: begin
        op         = OP_MUL_KT;
        state_next = ST_TAKE_KT;
      end
      ST_TAKE_KT: begin
        op         = OP_TAKE_KT;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        op         = OP_HOLD;
        // held integrator needs the i term from the old value
        state_next = sts.held ? ST_MUL_KA : ST_SUM;
      end
      ST_MUL_KA: begin
        op         = OP_MUL_KA;
        state_next = ST_TAKE_KA;
      end
      ST_TAKE_KA: begin
        op         = OP_TAKE_KA;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        op         = OP_SUM;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          op         = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_div_needs_history: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_START) |-> $past(sts.have_last))
    else $error("divider started without a previous measurement");
  a_ka_after_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_KA) |-> ($past(state) == ST_HOLD && $past(sts.held)))
    else $error("held path entered without a hold");
  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && sts.out_free) |=> (state == ST_IDLE))
    else $error("result written but controller did not return to idle");
`endif

endmodule

### verif/tb_pid_conditional_integration_top.sv
// testbench for pid_conditional_integration_top: directed and random control updates
// checked against a fixed-point predictor; needs pidci_pkg, pidci_in_if, pidci_out_if
module tb_pid_conditional_integration_top;
  import pidci_pkg::*;

  localparam logic [RegIdxW-1:0] RegUnused = 3'd7;
  localparam int NumRegs = 7;
  localparam int HoldCycles = 400;
  localparam int QuietLimit = 4000;
  localparam int TailCycles = 80;
  localparam int PhaseItems = 220;
  localparam logic signed [DataW-1:0] One = 32'sd65536;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    integ_held;
  } drive_result_t;

  typedef logic signed [DataW-1:0] reg_set_t [NumRegs];

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [RegIdxW-1:0] cfg_index;
  logic [DataW-1:0]   cfg_data;

  pidci_in_if  in_ch();
  pidci_out_if out_ch();

  pid_conditional_integration_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the gains, limits and loop state
  reg_set_t                cfg_shadow;
  logic signed [DataW-1:0] ctl_accum;
  logic signed [DataW-1:0] ctl_last;
  logic                    ctl_have_last;

  drive_result_t drive_q[$];
  int            fail_cnt = 0;
  bit            idle_on;
  int            hold_token = 0;
  int            walk_pos = 0;
  int            set_point = 65536;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint bound(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // q16.16 times q16.16, floor to q16.16, saturate
  function automatic longint qprod(input longint a, input longint b);
    return sat_word((a * b) >>> FracW);
  endfunction

  function automatic drive_result_t compute_drive(input logic m,
                                                  input logic signed [DataW-1:0] tgt,
                                                  input logic signed [DataW-1:0] sen,
                                                  input logic [StepW-1:0] dt);
    longint kp, ki, kd, dlo, dhi, alo, ahi;
    longint dtl, err, p_term, d_term, rate, tent, tent_out, i_term, sum;
    logic hold;
    drive_result_t r;
    r.drive = '0;
    r.integ_held = 1'b0;
    if (m) begin
      ctl_accum = '0;
      ctl_last = '0;
      ctl_have_last = 1'b0;
      return r;
    end
    if (dt == '0) return r;
    kp  = cfg_shadow[RegPropGain];
    ki  = cfg_shadow[RegIntegGain];
    kd  = cfg_shadow[RegDerivGain];
    dlo = cfg_shadow[RegDriveFloor];
    dhi = cfg_shadow[RegDriveCeiling];
    alo = cfg_shadow[RegAccumFloor];
    ahi = cfg_shadow[RegAccumCeiling];
    dtl = {33'b0, dt};
    err = sat_word(longint'(tgt) - longint'(sen));
    p_term = qprod(kp, err);
    d_term = 0;
    if (ctl_have_last) begin
      rate = sat_word(((longint'(sen) - longint'(ctl_last)) * 65536) / dtl);
      d_term = sat_word(-((kd * rate) >>> FracW));
    end
    ctl_last = sen;
    ctl_have_last = 1'b1;
    tent = longint'(ctl_accum) + ((err * dtl) >>> FracW);
    tent = bound(tent, alo, ahi);
    tent_out = p_term + qprod(ki, tent) + d_term;
    // integrator frozen when the output would saturate the same way as the error
    hold = (tent_out >= dhi && err > 0) || (tent_out <= dlo && err < 0);
    if (!hold) ctl_accum = tent[DataW-1:0];
    i_term = qprod(ki, longint'(ctl_accum));
    sum = bound(p_term + i_term + d_term, dlo, dhi);
    r.drive = sum[DataW-1:0];
    r.integ_held = hold;
    return r;
  endfunction

  // sink side: random stalls plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_cnt;
    hold_seen = 0;
    hold_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_cnt = HoldCycles;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 12);
      end
    end
  end

  always @(posedge clk) begin
    drive_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (drive_q.size() == 0) begin
        $error("unexpected result transaction: drive %0d integ_held %0b",
               out_ch.drive, out_ch.integ_held);
        fail_cnt++;
      end else begin
        want = drive_q.pop_front();
        if (out_ch.drive !== want.drive) begin
          $error("drive: expected %0d actual %0d", want.drive, out_ch.drive);
          fail_cnt++;
        end
        if (out_ch.integ_held !== want.integ_held) begin
          $error("integ_held: expected %0b actual %0b", want.integ_held, out_ch.integ_held);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_pid_conditional_integration_top NOT OK");
    $finish;
  end

  task automatic push_sample(input logic m, input logic signed [DataW-1:0] tgt,
                             input logic signed [DataW-1:0] sen, input logic [StepW-1:0] dt);
    while (idle_on && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.target    <= tgt;
    in_ch.sensed    <= sen;
    in_ch.step_time <= dt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    drive_q.push_back(compute_drive(m, tgt, sen, dt));
  endtask

  // mostly a measurement wandering around a setpoint, some raw full-range noise
  task automatic push_random_sample();
    logic                    m;
    logic signed [DataW-1:0] tgt;
    logic signed [DataW-1:0] sen;
    logic [StepW-1:0]        dt;
    int                      k;
    m = ($urandom_range(99) < 3);
    k = $urandom_range(99);
    if (k < 3) dt = '0;
    else if (k < 65) dt = StepW'($urandom_range(1, 131072));
    else if (k < 85) dt = StepW'($urandom);
    else if (k < 92) dt = '1;
    else dt = StepW'($urandom_range(1, 16));
    if ($urandom_range(99) < 75) begin
      walk_pos += int'($urandom_range(0, 131072)) - 65536;
      if (walk_pos > (1 << 24) || walk_pos < -(1 << 24)) walk_pos = 0;
      if ($urandom_range(99) < 5) set_point = int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
      tgt = set_point;
      sen = walk_pos;
    end else begin
      tgt = $urandom;
      sen = $urandom;
    end
    push_sample(m, tgt, sen, dt);
  endtask

  task automatic settle_pipeline();
    in_ch.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input reg_set_t vals);
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= RegIdxW'(i);
      cfg_data  <= vals[i];
      cfg_shadow[i] = vals[i];
      @(posedge clk);
    end
    // index past the last register must be ignored
    cfg_we    <= 1'b1;
    cfg_index <= RegUnused;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    reg_set_t set;
    settle_pipeline();
    set = '{One, One / 2, One / 4, -32'sd655360, 32'sd655360, -32'sd327680, 32'sd327680};
    load_config(set);
    push_sample(1'b1, Max32, Min32, '1);  // restart ignores its payload
    push_sample(1'b0, One, 32'sd0, '0);
    push_sample(1'b0, One, 32'sd0, 31'd655);  // first sample, no derivative
    push_sample(1'b0, One, One / 2, 31'd655);
    push_sample(1'b0, One, One / 2, 31'd655);
    push_sample(1'b0, Max32, Min32, 31'd1);  // error saturates
    push_sample(1'b0, Min32, Max32, '1);
    push_sample(1'b0, 32'sd0, Min32, 31'd1);  // rate saturates
    push_sample(1'b0, 32'sd0, Max32, 31'd1);
    push_sample(1'b0, One * 3, 32'sd0, '1);
    push_sample(1'b1, 32'sd0, 32'sd0, '0);

    // extreme gains, inverted limits
    settle_pipeline();
    set = '{Max32, Min32, Max32, One, -One, Max32, Min32};
    load_config(set);
    push_sample(1'b0, Max32, Min32, '1);
    push_sample(1'b0, Min32, Max32, 31'd1);
    push_sample(1'b0, 32'sd0, 32'sd0, 31'd1);
    push_sample(1'b0, -32'sd1, 32'sd0, '1);
    push_sample(1'b1, Max32, Max32, '1);

    settle_pipeline();
    set = '{Min32, Max32, Min32, Min32, Max32, Min32, Max32};
    load_config(set);
    push_sample(1'b0, One, -One, 31'd65536);
    push_sample(1'b0, Min32, Max32, '1);
    push_sample(1'b0, Max32, Min32, 31'd1);
    push_sample(1'b0, 32'sd0, 32'sd0, 31'd2);
  endtask

  task automatic test_backpressure();
    settle_pipeline();
    idle_on <= 1'b0;
    hold_token <= hold_token + 1;
    repeat (16) push_random_sample();
    settle_pipeline();
    idle_on <= 1'b1;
  endtask

  task automatic test_pause();
    settle_pipeline();
    repeat (25) push_random_sample();
    // sender waits for every outstanding result before going on
    settle_pipeline();
    repeat (25) push_random_sample();
  endtask

  task automatic test_random_phases();
    reg_set_t                set;
    logic signed [DataW-1:0] span;
    for (int ph = 0; ph < 7; ph++) begin
      settle_pipeline();
      for (int i = 0; i < 3; i++) set[i] = int'($urandom_range(0, 524288)) - 262144;
      span = int'($urandom_range(1, 64)) * 65536;
      set[RegDriveFloor]   = -span;
      set[RegDriveCeiling] = span;
      span = int'($urandom_range(1, 64)) * 65536;
      set[RegAccumFloor]   = -span;
      set[RegAccumCeiling] = span;
      case (ph)
        1: begin
          for (int i = 0; i < NumRegs; i++) set[i] = $urandom;
        end
        2: begin
          for (int i = 0; i < 3; i++) set[i] = $urandom_range(1) ? Max32 : Min32;
          set[RegDriveFloor]   = Min32;
          set[RegDriveCeiling] = Max32;
          set[RegAccumFloor]   = Min32;
          set[RegAccumCeiling] = Max32;
        end
        3: begin
          set[RegDriveFloor]   = span;
          set[RegDriveCeiling] = -span;
          set[RegAccumFloor]   = One;
          set[RegAccumCeiling] = -One;
        end
        4: begin
          set[RegDriveCeiling] = set[RegDriveFloor];
          set[RegAccumCeiling] = set[RegAccumFloor];
        end
        5: begin
          for (int i = 0; i < 3; i++) set[i] = int'($urandom_range(0, 1 << 25)) - (1 << 24);
          set[RegDriveFloor]   = -One;
          set[RegDriveCeiling] = One;
        end
        6: begin
          set[RegDriveFloor]   = LimitLowRst;
          set[RegDriveCeiling] = LimitHighRst;
          set[RegAccumFloor]   = LimitLowRst;
          set[RegAccumCeiling] = LimitHighRst;
        end
        default: begin
        end
      endcase
      load_config(set);
      repeat (PhaseItems) push_random_sample();
    end
  endtask

  task automatic test_no_idle();
    settle_pipeline();
    idle_on <= 1'b0;
    repeat (250) push_random_sample();
    settle_pipeline();
    idle_on <= 1'b1;
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= 1'b0;
    in_ch.target    <= '0;
    in_ch.sensed    <= '0;
    in_ch.step_time <= '0;
    idle_on         <= 1'b1;
    cfg_shadow = '{32'sd0, 32'sd0, 32'sd0, LimitLowRst, LimitHighRst, LimitLowRst, LimitHighRst};
    ctl_accum = '0;
    ctl_last = '0;
    ctl_have_last = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_pause();
    test_random_phases();
    test_no_idle();
    in_ch.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_pid_conditional_integration_top OK");
    end else begin
      $display("tb_pid_conditional_integration_top NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
design/pidci_pkg.sv
design/pidci_if.sv
design/pidci_regs.sv
design/pidci_dp.sv
design/pidci_ctrl.sv
design/pid_conditional_integration_top.sv
verif/tb_pid_conditional_integration_top.sv
